// File: hdl/base64_dump_encoder_crc32_top_defines.svh
// Assertion macros shared by the checker of the base64 dump encoder.
// Depends on nothing; every macro expects clk and rst_n in scope.
`ifndef BASE64_DUMP_ENCODER_CRC32_TOP_DEFINES_SVH
`define BASE64_DUMP_ENCODER_CRC32_TOP_DEFINES_SVH

// A condition that must hold at every edge outside reset.
`define B64CRC_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// A condition that implies another at the same edge.
`define B64CRC_ASSERT_IMPLY(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// A signal that must keep its value across a stalled edge.
`define B64CRC_ASSERT_HOLD(label, valid, ready, sig, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        ((valid) && !(ready)) |=> $stable(sig)) else $error(msg);

`endif

// File: hdl/b64crc_pkg.sv
// Package of the base64 dump encoder: constants, the queue entry type,
// the group phase type and the alphabet and CRC-32 functions. No dependencies.
`default_nettype none

package b64crc_pkg;

    localparam int CHUNK_BYTES_DEF = 48;
    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int COUNT_W         = 6;
    localparam int CHAR_W          = 7;
    localparam int CRC_W           = 32;
    localparam int MAX_CHARS       = 4;

    localparam logic [CRC_W-1:0]  CRC_POLY = 32'hEDB8_8320;
    localparam logic [CRC_W-1:0]  CRC_INIT = 32'hFFFF_FFFF;
    localparam logic [CHAR_W-1:0] PAD_CHAR = 7'h3D;

    // Position of the next byte within its three-byte group.
    typedef enum logic [1:0] {
        PH_FIRST,
        PH_SECOND,
        PH_THIRD
    } phase_t;

    // All characters that one input byte causes, with their end marks.
    typedef struct packed {
        logic [MAX_CHARS-1:0][CHAR_W-1:0] chars;
        logic [1:0]                       last_idx;
        logic                             chunk_end;
        logic                             stream_end;
        logic [CRC_W-1:0]                 crc;
    } job_t;

    function automatic logic [CHAR_W-1:0] b64_char(input logic [5:0] v);
        logic [CHAR_W-1:0] c;
        if (v < 6'd26) begin
            c = 7'd65 + {1'b0, v};
        end
        else if (v < 6'd52) begin
            c = 7'd71 + {1'b0, v};
        end
        else if (v < 6'd62) begin
            c = {1'b0, v} - 7'd4;
        end
        else if (v == 6'd62) begin
            c = 7'h2B;
        end
        else begin
            c = 7'h2F;
        end
        return c;
    endfunction

    // One byte through the reflected CRC-32, bit by bit.
    function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc_in,
                                                 input logic [7:0] b);
        logic [CRC_W-1:0] c;
        c = crc_in ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// File: hdl/b64crc_if.sv
// Valid/ready channel interfaces of the base64 dump encoder: dump bytes in,
// text characters out. Depends on b64crc_pkg.
`default_nettype none

interface b64crc_in_if
    import b64crc_pkg::*;
;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       final_byte;

    modport source (output valid, output data_byte, output final_byte, input ready);
    modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

interface b64crc_out_if
    import b64crc_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] text_char;
    logic              run_last;
    logic              chunk_end;
    logic              stream_end;
    logic [CRC_W-1:0]  crc_value;

    modport source (output valid, output text_char, output run_last, output chunk_end,
                    output stream_end, output crc_value, input ready);
    modport sink   (input valid, input text_char, input run_last, input chunk_end,
                    input stream_end, input crc_value, output ready);
endinterface

`default_nettype wire

// File: hdl/b64crc_front.sv
// Front end: takes dump bytes, runs the CRC, group and chunk bookkeeping and
// builds one queue entry per byte. Depends on b64crc_pkg.
`default_nettype none

module b64crc_front
    import b64crc_pkg::*;
#(
    parameter int CHUNK_BYTES = CHUNK_BYTES_DEF
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output      logic       in_ready,
    input  wire logic [7:0] data_byte,
    input  wire logic       final_byte,
    input  wire logic       queue_full,
    output      logic       push,
    output      job_t       job
);

    phase_t             phase_reg, phase_next;
    logic [3:0]         left_reg, left_next;
    logic [CRC_W-1:0]   crc_reg, crc_next;
    logic [COUNT_W-1:0] count_reg, count_next;

    logic [CRC_W-1:0]   crc_upd;
    logic [COUNT_W:0]   count_sum;
    logic               cend;
    phase_t             phase_after;
    logic [3:0]         left_after;

    assign in_ready = !queue_full;
    assign push     = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_FIRST;
            left_reg  <= '0;
            crc_reg   <= CRC_INIT;
            count_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            left_reg  <= left_next;
            crc_reg   <= crc_next;
            count_reg <= count_next;
        end
    end

    always_comb
    begin
        crc_upd   = crc_byte(crc_reg, data_byte);
        count_sum = {1'b0, count_reg} + (COUNT_W+1)'(1);
        cend      = final_byte || (count_sum >= (COUNT_W+1)'(CHUNK_BYTES));

        job.chars      = {MAX_CHARS{PAD_CHAR}};
        job.last_idx   = 2'd0;
        phase_after    = PH_FIRST;
        left_after     = '0;

        unique case (phase_reg)
            PH_FIRST:
            begin
                job.chars[0] = b64_char(data_byte[7:2]);
                left_after   = {2'b00, data_byte[1:0]};
                phase_after  = PH_SECOND;
            end
            PH_SECOND:
            begin
                job.chars[0] = b64_char({left_reg[1:0], data_byte[7:4]});
                left_after   = data_byte[3:0];
                phase_after  = PH_THIRD;
            end
            PH_THIRD:
            begin
                job.chars[0] = b64_char({left_reg, data_byte[7:6]});
                job.chars[1] = b64_char(data_byte[5:0]);
                job.last_idx = 2'd1;
            end
            default:
            begin
                job.chars[0] = PAD_CHAR;
            end
        endcase

        // Flush the partial group; the pad characters are already preset.
        if (cend)
        begin
            if (phase_after == PH_SECOND)
            begin
                job.chars[1] = b64_char({left_after[1:0], 4'b0000});
                job.last_idx = 2'd3;
            end
            else if (phase_after == PH_THIRD)
            begin
                job.chars[1] = b64_char({left_after, 2'b00});
                job.last_idx = 2'd2;
            end
        end

        job.chunk_end  = cend;
        job.stream_end = final_byte;
        job.crc        = final_byte ? ~crc_upd : '0;

        phase_next = phase_reg;
        left_next  = left_reg;
        crc_next   = crc_reg;
        count_next = count_reg;
        if (push)
        begin
            phase_next = cend ? PH_FIRST : phase_after;
            left_next  = cend ? 4'd0 : left_after;
            crc_next   = final_byte ? CRC_INIT : crc_upd;
            count_next = cend ? '0 : count_sum[COUNT_W-1:0];
        end
    end

endmodule

`default_nettype wire

// File: hdl/b64crc_fifo.sv
// Short queue of per-byte jobs between the front and back ends.
// Depends on b64crc_pkg.
`default_nettype none

module b64crc_fifo
    import b64crc_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire job_t wr_job,
    input  wire logic pop,
    output      job_t rd_job,
    output      logic full,
    output      logic empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full   = (count_reg == CNT_W'(DEPTH));
    assign empty  = (count_reg == '0);
    assign rd_job = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wr_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

endmodule

`default_nettype wire

// File: hdl/b64crc_back.sv
// Back end: walks the characters of the queue head one per cycle, while the
// receiver takes them, into the output register. Depends on b64crc_pkg.
`default_nettype none

module b64crc_back
    import b64crc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire job_t              head,
    input  wire logic              empty,
    output      logic              pop,
    output      logic              out_valid,
    input  wire logic              out_ready,
    output      logic [CHAR_W-1:0] text_char,
    output      logic              run_last,
    output      logic              chunk_end,
    output      logic              stream_end,
    output      logic [CRC_W-1:0]  crc_value
);

    logic [1:0]        idx_reg, idx_next;
    logic              valid_reg, valid_next;
    logic [CHAR_W-1:0] char_reg;
    logic              last_reg, cend_reg, send_reg;
    logic [CRC_W-1:0]  crc_reg;

    logic              emit;
    logic              at_last;

    assign emit    = (!valid_reg || out_ready) && !empty;
    assign at_last = (idx_reg == head.last_idx);
    assign pop     = emit && at_last;

    assign out_valid  = valid_reg;
    assign text_char  = char_reg;
    assign run_last   = last_reg;
    assign chunk_end  = cend_reg;
    assign stream_end = send_reg;
    assign crc_value  = crc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            char_reg <= head.chars[idx_reg];
            last_reg <= at_last;
            cend_reg <= at_last && head.chunk_end;
            send_reg <= at_last && head.stream_end;
            crc_reg  <= at_last ? head.crc : '0;
        end
    end

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (emit)
        begin
            idx_next   = at_last ? 2'd0 : idx_reg + 2'd1;
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

endmodule

`default_nettype wire

// File: hdl/base64_dump_encoder_crc32_top.sv
// A byte taken is written to the job queue, then its first character to the output register.
// Throughput: one character per cycle through the single output register while the receiver
// is ready; a byte gives one or two characters in a group and up to four on a padded flush.
// The job queue (QUEUE_DEPTH entries) lets input continue while output stalls.
// Reset: asynchronous, active low; clears phase, chunk count, queue and output,
// loads the CRC with all ones. No clearing pass is needed.
`default_nettype none

module base64_dump_encoder_crc32_top
    import b64crc_pkg::*;
#(
    parameter int CHUNK_BYTES = CHUNK_BYTES_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input wire logic   clk,
    input wire logic   rst_n,
    b64crc_in_if.sink  dump,
    b64crc_out_if.source text
);

    job_t front_job;
    job_t head_job;
    logic push;
    logic pop;
    logic queue_full;
    logic queue_empty;

    b64crc_front #(
        .CHUNK_BYTES (CHUNK_BYTES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (dump.valid),
        .in_ready   (dump.ready),
        .data_byte  (dump.data_byte),
        .final_byte (dump.final_byte),
        .queue_full (queue_full),
        .push       (push),
        .job        (front_job)
    );

    b64crc_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wr_job (front_job),
        .pop    (pop),
        .rd_job (head_job),
        .full   (queue_full),
        .empty  (queue_empty)
    );

    b64crc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head_job),
        .empty      (queue_empty),
        .pop        (pop),
        .out_valid  (text.valid),
        .out_ready  (text.ready),
        .text_char  (text.text_char),
        .run_last   (text.run_last),
        .chunk_end  (text.chunk_end),
        .stream_end (text.stream_end),
        .crc_value  (text.crc_value)
    );

endmodule

`default_nettype wire

// File: hdl/b64crc_checker.sv
// Port-level checker of the base64 dump encoder and its bind to the top level.
// Depends on b64crc_pkg and base64_dump_encoder_crc32_top_defines.svh.
`default_nettype none
`include "base64_dump_encoder_crc32_top_defines.svh"

module b64crc_checker
    import b64crc_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              out_valid,
    input wire logic              out_ready,
    input wire logic [CHAR_W-1:0] text_char,
    input wire logic              run_last,
    input wire logic              chunk_end,
    input wire logic              stream_end,
    input wire logic [CRC_W-1:0]  crc_value
);

    `B64CRC_ASSERT_HOLD(a_valid_hold, out_valid, out_ready, out_valid, "output valid dropped while stalled")
    `B64CRC_ASSERT_HOLD(a_char_hold, out_valid, out_ready, text_char, "output character changed while stalled")
    `B64CRC_ASSERT_IMPLY(a_end_marks, out_valid && stream_end, chunk_end && run_last, "dump end without chunk end and run end")
    `B64CRC_ASSERT_IMPLY(a_chunk_run, out_valid && chunk_end, run_last, "chunk end not on the last character of a byte")
    `B64CRC_ASSERT_ALWAYS(a_crc_zero, !out_valid || stream_end || crc_value == '0, "CRC shown before the end of the dump")

endmodule

bind base64_dump_encoder_crc32_top b64crc_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (text.valid),
    .out_ready  (text.ready),
    .text_char  (text.text_char),
    .run_last   (text.run_last),
    .chunk_end  (text.chunk_end),
    .stream_end (text.stream_end),
    .crc_value  (text.crc_value)
);

`default_nettype wire

// File: tb/tb.sv
// Self-checking testbench of base64_dump_encoder_crc32_top: random dumps in, base64 text out.
// Depends on b64crc_pkg, the b64crc_in_if / b64crc_out_if interfaces and the encoder RTL.
`timescale 1ns / 100ps

module tb;
    import b64crc_pkg::*;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } dump_byte_t;

    typedef struct {
        logic [CHAR_W-1:0] ch;
        logic              run_last;
        logic              chunk_end;
        logic              stream_end;
        logic [CRC_W-1:0]  crc;
    } text_char_t;

    localparam bit [0:63][7:0] B64_ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    logic clk;
    logic rst_n;

    b64crc_in_if  dump_ch ();
    b64crc_out_if text_ch ();

    base64_dump_encoder_crc32_top DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .dump  (dump_ch),
        .text  (text_ch)
    );

    dump_byte_t pending_bytes[$];
    text_char_t expected_text[$];
    int         bytes_total;
    int         bytes_taken = 0;
    int         chars_seen  = 0;
    int         error_count = 0;

    // Encoder state mirrored by the predictor.
    phase_t             enc_phase;
    logic [3:0]         enc_carry;
    logic [COUNT_W-1:0] enc_chunk_bytes;
    logic [CRC_W-1:0]   enc_crc;

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic logic [CHAR_W-1:0] b64_symbol(input logic [5:0] v);
        return B64_ALPHABET[v][CHAR_W-1:0];
    endfunction

    function automatic logic [CRC_W-1:0] crc32_update(input logic [CRC_W-1:0] c,
                                                      input logic [7:0] b);
        logic [CRC_W-1:0] r;
        r = c ^ {24'd0, b};
        for (int i = 0; i < 8; i++)
        begin
            r = (r >> 1) ^ (r[0] ? CRC_POLY : {CRC_W{1'b0}});
        end
        return r;
    endfunction

    task automatic reset_encoder_state();
        enc_phase       = PH_FIRST;
        enc_carry       = 4'd0;
        enc_chunk_bytes = '0;
        enc_crc         = CRC_INIT;
    endtask

    // Works out every character that one accepted byte causes and queues them.
    task automatic encode_byte(input logic [7:0] b, input logic last);
        logic [CHAR_W-1:0] chars[4];
        int                n;
        logic              at_chunk_end;
        text_char_t        t;
        n = 0;
        enc_crc = crc32_update(enc_crc, b);
        case (enc_phase)
            PH_FIRST:
            begin
                chars[n] = b64_symbol(b[7:2]);
                n++;
                enc_carry = {2'b00, b[1:0]};
                enc_phase = PH_SECOND;
            end
            PH_SECOND:
            begin
                chars[n] = b64_symbol({enc_carry[1:0], b[7:4]});
                n++;
                enc_carry = b[3:0];
                enc_phase = PH_THIRD;
            end
            default:
            begin
                chars[n] = b64_symbol({enc_carry, b[7:6]});
                n++;
                chars[n] = b64_symbol(b[5:0]);
                n++;
                enc_carry = 4'd0;
                enc_phase = PH_FIRST;
            end
        endcase
        enc_chunk_bytes = enc_chunk_bytes + 1'b1;
        at_chunk_end = last || (enc_chunk_bytes >= CHUNK_BYTES_DEF);
        if (at_chunk_end)
        begin
            if (enc_phase == PH_SECOND)
            begin
                chars[n] = b64_symbol({enc_carry[1:0], 4'b0000});
                chars[n + 1] = PAD_CHAR;
                chars[n + 2] = PAD_CHAR;
                n += 3;
            end
            else if (enc_phase == PH_THIRD)
            begin
                chars[n] = b64_symbol({enc_carry, 2'b00});
                chars[n + 1] = PAD_CHAR;
                n += 2;
            end
            enc_phase       = PH_FIRST;
            enc_carry       = 4'd0;
            enc_chunk_bytes = '0;
        end
        for (int i = 0; i < n; i++)
        begin
            t.ch         = chars[i];
            t.run_last   = (i == n - 1);
            t.chunk_end  = (i == n - 1) && at_chunk_end;
            t.stream_end = (i == n - 1) && last;
            t.crc        = ((i == n - 1) && last) ? ~enc_crc : {CRC_W{1'b0}};
            expected_text.push_back(t);
        end
        if (last)
        begin
            reset_encoder_state();
        end
    endtask

    task automatic report_mismatch(input string what, input logic [CRC_W-1:0] want,
                                   input logic [CRC_W-1:0] got);
        $display("MISMATCH char %0d %s: expected %h, got %h", chars_seen, what, want, got);
        error_count++;
    endtask

    task automatic add_dump(input int len, input bit edge_values);
        dump_byte_t d;
        for (int i = 0; i < len; i++)
        begin
            if (edge_values && $urandom_range(0, 3) == 0)
            begin
                d.data = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            end
            else
            begin
                d.data = $urandom_range(0, 255);
            end
            d.last = (i == len - 1);
            pending_bytes.push_back(d);
        end
    endtask

    task automatic add_directed(input logic [7:0] b, input logic last);
        dump_byte_t d;
        d.data = b;
        d.last = last;
        pending_bytes.push_back(d);
    endtask

    // Sender: bursts of random length separated by random gaps.
    int  burst_left;
    int  gap_left;
    logic       next_valid;
    dump_byte_t next_byte;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dump_ch.valid      <= 1'b0;
            dump_ch.data_byte  <= 8'd0;
            dump_ch.final_byte <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
            reset_encoder_state();
        end
        else
        begin
            if (dump_ch.valid && dump_ch.ready)
            begin
                encode_byte(dump_ch.data_byte, dump_ch.final_byte);
                bytes_taken++;
            end
            if (!(dump_ch.valid && !dump_ch.ready))
            begin
                next_valid = 1'b0;
                if (gap_left > 0)
                begin
                    gap_left--;
                end
                else if (pending_bytes.size() > 0)
                begin
                    if (burst_left == 0)
                    begin
                        if ($urandom_range(0, 4) == 0)
                        begin
                            burst_left = 60;
                        end
                        else
                        begin
                            burst_left = $urandom_range(1, 20);
                        end
                    end
                    next_byte  = pending_bytes.pop_front();
                    next_valid = 1'b1;
                    burst_left--;
                    if (burst_left == 0)
                    begin
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                    dump_ch.data_byte  <= next_byte.data;
                    dump_ch.final_byte <= next_byte.last;
                end
                dump_ch.valid <= next_valid;
            end
        end
    end

    // Receiver: ready follows one of four stall patterns, drawn anew at random as the test runs.
    int unsigned cycle_count;
    int unsigned stall_mode;
    text_char_t  want;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_ch.ready <= 1'b0;
            cycle_count = 0;
            stall_mode  = 0;
        end
        else
        begin
            if (text_ch.valid && text_ch.ready)
            begin
                if (expected_text.size() == 0)
                begin
                    report_mismatch("unexpected text_char", '0, text_ch.text_char);
                end
                else
                begin
                    want = expected_text.pop_front();
                    if (text_ch.text_char !== want.ch)
                        report_mismatch("text_char", want.ch, text_ch.text_char);
                    if (text_ch.run_last !== want.run_last)
                        report_mismatch("run_last", want.run_last, text_ch.run_last);
                    if (text_ch.chunk_end !== want.chunk_end)
                        report_mismatch("chunk_end", want.chunk_end, text_ch.chunk_end);
                    if (text_ch.stream_end !== want.stream_end)
                        report_mismatch("stream_end", want.stream_end, text_ch.stream_end);
                    if (text_ch.crc_value !== want.crc)
                        report_mismatch("crc_value", want.crc, text_ch.crc_value);
                end
                chars_seen++;
            end
            cycle_count++;
            if (cycle_count % 50 == 0)
            begin
                stall_mode = $urandom_range(0, 3);
            end
            case (stall_mode)
                0:       text_ch.ready <= 1'b1;
                1:       text_ch.ready <= ($urandom_range(0, 3) != 0);
                2:       text_ch.ready <= (cycle_count % 4 != 3);
                default: text_ch.ready <= (cycle_count % 8 < 2);
            endcase
        end
    end

    initial
    begin
        int dump_len;
        bit dump_edges;
        rst_n = 1'b0;

        // Single-byte dumps at both extremes (two pads each), then the one- and zero-pad cases.
        add_directed(8'h00, 1'b1);
        add_directed(8'hFF, 1'b1);
        add_directed("M", 1'b0);
        add_directed("a", 1'b1);
        add_directed("M", 1'b0);
        add_directed("a", 1'b0);
        add_directed("n", 1'b1);
        // Groups that reach the last two alphabet entries.
        add_directed(8'hFB, 1'b0);
        add_directed(8'hEF, 1'b0);
        add_directed(8'hBE, 1'b1);
        add_directed(8'hFF, 1'b0);
        add_directed(8'hFF, 1'b0);
        add_directed(8'hFF, 1'b0);
        add_directed(8'h00, 1'b0);
        add_directed(8'h00, 1'b0);
        add_directed(8'h00, 1'b0);
        add_directed(8'h80, 1'b0);
        add_directed(8'h01, 1'b0);
        add_directed(8'h7F, 1'b1);

        // Mostly short dumps, some longer ones that cross or land on chunk boundaries.
        while (pending_bytes.size() < 310)
        begin
            dump_edges = 1'b0;
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5:
                begin
                    dump_len   = $urandom_range(1, 9);
                    dump_edges = 1'b1;
                end
                6, 7:    dump_len = $urandom_range(10, 30);
                8:       dump_len = CHUNK_BYTES_DEF - 1 + $urandom_range(0, 2);
                default: dump_len = $urandom_range(50, 2 * CHUNK_BYTES_DEF);
            endcase
            if (dump_len > 310 - pending_bytes.size())
            begin
                dump_len = 310 - pending_bytes.size();
            end
            add_dump(dump_len, dump_edges);
        end
        bytes_total = pending_bytes.size();

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (bytes_taken < bytes_total || expected_text.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);

        if (error_count == 0 && expected_text.size() == 0)
        begin
            $display("tb passed");
        end
        else
        begin
            $display("tb failed");
        end
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("tb failed");
        $finish;
    end

endmodule
